// ===== rtl/plb_pkg.sv =====
// Shared types and constants for the posting list builder.
// Holds the hit and record transfer types and the bundle passed from core to emitter.
// No dependencies.
package plb_pkg;

  localparam int POS_W     = 29;
  localparam int FIELD_LSB = 24;
  localparam int FIELD_MSB = 28;

  localparam logic [1:0] KIND_HIT  = 2'd0;
  localparam logic [1:0] KIND_DOC  = 2'd1;
  localparam logic [1:0] KIND_WORD = 2'd2;

  typedef struct packed {
    logic [63:0]      hit_word;
    logic [63:0]      hit_doc;
    logic [POS_W-1:0] hit_position;
    logic             flush;
  } hit_t;

  typedef struct packed {
    logic [1:0]       record_kind;
    logic [63:0]      record_id;
    logic [31:0]      field_mask;
    logic [31:0]      doc_count;
    logic [31:0]      hit_count;
    logic [31:0]      start_index;
    logic [POS_W-1:0] position_out;
    logic             last;
  } record_t;

  // Up to three records caused by one hit, emitted in the order doc, word, hit.
  typedef struct packed {
    logic             has_doc;
    logic             has_word;
    logic             has_hit;
    logic [63:0]      doc_id;
    logic [31:0]      doc_mask;
    logic [31:0]      doc_hits;
    logic [31:0]      doc_start;
    logic [63:0]      word_id;
    logic [31:0]      word_docs;
    logic [31:0]      word_hits;
    logic [31:0]      word_start;
    logic [POS_W-1:0] position;
  } bundle_t;

endpackage

// ===== rtl/posting_list_builder_top.sv =====
// Posting list builder top level: joins the core and the emitter.
// Depends on plb_pkg, plb_core and plb_emit.
//
// Hits sorted by word, document and position enter on the hit channel
// (hit, hit_valid, hit_stall); records leave on the rec channel
// (rec, rec_valid, rec_stall). Each hit yields a hit record, preceded by a
// document record when the document or word changes and a document is
// pending, and by a word record when the word changes and a word is pending.
// A flush item sends the pending document and word records and clears all
// counts; with nothing pending it yields no record. rec.last marks the final
// record of each item.
// The first record of an item is offered from the emitter's bundle register
// once the item has passed through the input register. Throughput: one item
// per cycle while each item yields one record and rec_stall is low, since
// the emitter sends one record per cycle from its bundle register.
// A new hit is taken into the input register while the previous bundle is
// still being sent. When the receiver stalls, the offered record holds and
// hit_stall rises once the input register is full.
// Reset clears all counts and drops any held item and record.
module posting_list_builder_top (
  input  logic             clk,
  input  logic             rst,
  input  plb_pkg::hit_t    hit,
  input  logic             hit_valid,
  output logic             hit_stall,
  output plb_pkg::record_t rec,
  output logic             rec_valid,
  input  logic             rec_stall
);
  import plb_pkg::*;

  logic    emit_free;
  logic    load;
  bundle_t bundle;

  plb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .hit       (hit),
    .hit_valid (hit_valid),
    .hit_stall (hit_stall),
    .emit_free (emit_free),
    .load      (load),
    .bundle    (bundle)
  );

  plb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .bundle    (bundle),
    .emit_free (emit_free),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall)
  );

endmodule

// ===== rtl/plb_core.sv =====
// Posting list builder core: input register, index state and record bundle build.
// Depends on plb_pkg.
module plb_core (
  input  logic           clk,
  input  logic           rst,
  input  plb_pkg::hit_t  hit,
  input  logic           hit_valid,
  output logic           hit_stall,
  input  logic           emit_free,
  output logic           load,
  output plb_pkg::bundle_t bundle
);
  import plb_pkg::*;

  logic        pend;
  hit_t        pend_hit;
  logic        take;

  logic [63:0] current_word, current_word_next;
  logic [63:0] current_doc, current_doc_next;
  logic [31:0] doc_field_bits, doc_field_bits_next;
  logic [31:0] doc_hit_total, doc_hit_total_next;
  logic [31:0] doc_hit_start, doc_hit_start_next;
  logic [31:0] word_doc_total, word_doc_total_next;
  logic [31:0] word_hit_total, word_hit_total_next;
  logic [31:0] word_doc_start, word_doc_start_next;
  logic [31:0] hits_written, hits_written_next;
  logic [31:0] docs_written, docs_written_next;

  logic        word_change, doc_change, close_doc, close_word;
  logic [31:0] wdt_closed, wht_closed, dw_closed, field_bit;

  assign take      = pend && emit_free;
  assign hit_stall = pend && !emit_free;

  always_comb begin
    word_change = !pend_hit.flush && (pend_hit.hit_word != current_word);
    doc_change  = word_change || (!pend_hit.flush && (pend_hit.hit_doc != current_doc));
    close_doc   = (pend_hit.flush || doc_change) && (current_doc != 64'd0);
    close_word  = (pend_hit.flush || word_change) && (current_word != 64'd0);

    wdt_closed = word_doc_total + {31'd0, close_doc};
    wht_closed = word_hit_total + (close_doc ? doc_hit_total : 32'd0);
    dw_closed  = docs_written + {31'd0, close_doc};
    field_bit  = 32'd1 << pend_hit.hit_position[FIELD_MSB:FIELD_LSB];

    bundle.has_doc    = close_doc;
    bundle.has_word   = close_word;
    bundle.has_hit    = !pend_hit.flush;
    bundle.doc_id     = current_doc;
    bundle.doc_mask   = doc_field_bits;
    bundle.doc_hits   = doc_hit_total;
    bundle.doc_start  = doc_hit_start;
    bundle.word_id    = current_word;
    bundle.word_docs  = wdt_closed;
    bundle.word_hits  = wht_closed;
    bundle.word_start = word_doc_start;
    bundle.position   = pend_hit.hit_position;

    load = take && (close_doc || close_word || !pend_hit.flush);

    if (pend_hit.flush) begin
      current_word_next   = '0;
      current_doc_next    = '0;
      doc_field_bits_next = '0;
      doc_hit_total_next  = '0;
      doc_hit_start_next  = '0;
      word_doc_total_next = '0;
      word_hit_total_next = '0;
      word_doc_start_next = '0;
      hits_written_next   = '0;
      docs_written_next   = '0;
    end else begin
      current_word_next   = pend_hit.hit_word;
      current_doc_next    = doc_change ? pend_hit.hit_doc : current_doc;
      doc_field_bits_next = (close_doc ? 32'd0 : doc_field_bits) | field_bit;
      doc_hit_total_next  = (close_doc ? 32'd0 : doc_hit_total) + 32'd1;
      doc_hit_start_next  = close_doc ? hits_written : doc_hit_start;
      word_doc_total_next = word_change ? 32'd0 : wdt_closed;
      word_hit_total_next = word_change ? 32'd0 : wht_closed;
      word_doc_start_next = word_change ? dw_closed : word_doc_start;
      hits_written_next   = hits_written + 32'd1;
      docs_written_next   = dw_closed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (hit_valid && !hit_stall) begin
      pend <= 1'b1;
    end else if (take) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_valid && !hit_stall) begin
      pend_hit <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_word   <= '0;
      current_doc    <= '0;
      doc_field_bits <= '0;
      doc_hit_total  <= '0;
      doc_hit_start  <= '0;
      word_doc_total <= '0;
      word_hit_total <= '0;
      word_doc_start <= '0;
      hits_written   <= '0;
      docs_written   <= '0;
    end else if (take) begin
      current_word   <= current_word_next;
      current_doc    <= current_doc_next;
      doc_field_bits <= doc_field_bits_next;
      doc_hit_total  <= doc_hit_total_next;
      doc_hit_start  <= doc_hit_start_next;
      word_doc_total <= word_doc_total_next;
      word_hit_total <= word_hit_total_next;
      word_doc_start <= word_doc_start_next;
      hits_written   <= hits_written_next;
      docs_written   <= docs_written_next;
    end
  end

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    take && pend_hit.flush |=> current_word == 64'd0 && current_doc == 64'd0 &&
                               hits_written == 32'd0 && docs_written == 32'd0)
    else $error("flush did not clear index state");

  a_word_follows: assert property (@(posedge clk) disable iff (rst)
    take && !pend_hit.flush |=> current_word == $past(pend_hit.hit_word))
    else $error("current word not taken from hit");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    take && !pend_hit.flush |=> hits_written == $past(hits_written) + 32'd1)
    else $error("hit not counted");

endmodule

// ===== rtl/plb_emit.sv =====
// Posting list builder emitter: holds one record bundle and sends its records one per transfer.
// Depends on plb_pkg.
module plb_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  plb_pkg::bundle_t bundle,
  output logic             emit_free,
  output plb_pkg::record_t rec,
  output logic             rec_valid,
  input  logic             rec_stall
);
  import plb_pkg::*;

  bundle_t     held;
  logic [2:0]  rem, rem_next;
  logic        xfer, last_one;

  assign rec_valid = |rem;
  assign xfer      = rec_valid && !rec_stall;
  assign last_one  = (rem & (rem - 3'd1)) == 3'd0;
  assign emit_free = !rec_valid || (xfer && last_one);

  always_comb begin
    rec = '0;
    rec.last = last_one;
    if (rem[0]) begin
      rec.record_kind = KIND_DOC;
      rec.record_id   = held.doc_id;
      rec.field_mask  = held.doc_mask;
      rec.hit_count   = held.doc_hits;
      rec.start_index = held.doc_start;
    end else if (rem[1]) begin
      rec.record_kind = KIND_WORD;
      rec.record_id   = held.word_id;
      rec.doc_count   = held.word_docs;
      rec.hit_count   = held.word_hits;
      rec.start_index = held.word_start;
    end else begin
      rec.record_kind  = KIND_HIT;
      rec.position_out = held.position;
    end
  end

  always_comb begin
    rem_next = rem;
    if (xfer) begin
      // drop the lowest pending record
      rem_next = rem & (rem - 3'd1);
    end
    if (load) begin
      rem_next = {bundle.has_hit, bundle.has_word, bundle.has_doc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else begin
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> rem == 3'd0 || (xfer && last_one))
    else $error("bundle loaded over pending records");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_stall |=> rec_valid && $stable(rem))
    else $error("pending records changed under stall");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    xfer && rec.last && !load |=> rem == 3'd0)
    else $error("records remain after last transfer");

endmodule
